FILE: rtl/buffered_uart_line_engine_core_assert.svh
// ----------------------------------------------------------------------------
// buffered_uart_line_engine_core_assert.svh
// Assertion macros for the serial buffer engine datapath (bule_dp).
// ----------------------------------------------------------------------------
`ifndef BUFFERED_UART_LINE_ENGINE_CORE_ASSERT_SVH
`define BUFFERED_UART_LINE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BULE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BULE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bule_pkg.sv
// ----------------------------------------------------------------------------
// bule_pkg
// Payload types, operation and status codes, and controller/datapath
// command and status structs for the serial buffer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bule_pkg;

    // Operation codes
    localparam logic [2:0] OP_RX_BYTE = 3'd0;
    localparam logic [2:0] OP_TX_DONE = 3'd1;
    localparam logic [2:0] OP_PUT     = 3'd2;
    localparam logic [2:0] OP_GET     = 3'd3;
    localparam logic [2:0] OP_GET_NUM = 3'd4;

    // Status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EMPTY    = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_NO_LINE  = 3'd3;
    localparam logic [2:0] STS_INVALID  = 3'd4;
    localparam logic [2:0] STS_OVERFLOW = 3'd5;

    // Characters
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic [7:0] read_byte;
        logic [6:0] number_value;
        logic [2:0] status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch input item, start scan at receive read pointer
        logic step;     // advance scan pointer, one fewer byte left
        logic rescan;   // LF found: restart scan at receive read pointer
        logic take;     // keep front byte as digit if fewer than two held
        logic mark_cr;  // CR reached at the front
        logic finish;   // commit state and write result
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       rx_full;
        logic       left_zero;
        logic       left_one;
        logic       byte_is_lf;
        logic       byte_is_cr;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/buffered_uart_line_engine_core.sv
// ----------------------------------------------------------------------------
// buffered_uart_line_engine_core
// Serial buffer engine: receive and transmit ring FIFOs serving line-side
// and host-side operations, with a two-digit line parser.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake          | Payload
//  s_      | in  | s_valid / s_ready  | in_item_t  (operation, data_byte)
//  m_      | out | m_valid / m_ready  | out_item_t (line, read, number, status)
//
//  One item at a time; one result per item, held in an output register.
//  Plain operations are committed once the output register is free. Get
//  number walks the held bytes looking for LF, then pops bytes from the
//  receive read pointer up to and including the CR, plus one byte after
//  it if any. The ring memories are read one byte a cycle; no clearing
//  pass after reset. A stalled result holds the commit of the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module buffered_uart_line_engine_core
    import bule_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    bule_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bule_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire

FILE: rtl/bule_ctrl.sv
// ----------------------------------------------------------------------------
// bule_ctrl
// Sequencer for the serial buffer engine: accepts an item, walks the
// receive FIFO for get number, and schedules the commit of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module bule_ctrl
    import bule_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire dp_sts_t   sts,
    output ctl_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PARSE = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.op == OP_GET_NUM && !sts.rx_full && !sts.left_zero) begin
                    state_next = S_SCAN;
                end else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // look for LF among the held bytes
            S_SCAN: begin
                if (sts.byte_is_lf) begin
                    cmd.rescan = 1'b1;
                    state_next = S_PARSE;
                end else begin
                    cmd.step = 1'b1;
                    if (sts.left_one) begin
                        state_next = S_DONE;
                    end
                end
            end
            // pop up to the CR, keeping the first two bytes
            S_PARSE: begin
                if (sts.left_zero) begin
                    state_next = S_DONE;
                end else if (sts.byte_is_cr) begin
                    cmd.mark_cr = 1'b1;
                    cmd.step    = 1'b1;
                    state_next  = S_TAIL;
                end else begin
                    cmd.take = 1'b1;
                    cmd.step = 1'b1;
                end
            end
            // one more byte after the CR, if any
            S_TAIL: begin
                cmd.step   = !sts.left_zero;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bule_dp.sv
// ----------------------------------------------------------------------------
// bule_dp
// Datapath of the serial buffer engine: receive and transmit ring memories,
// pointers and counts, get-number scan registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buffered_uart_line_engine_core_assert.svh"

module bule_dp
    import bule_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data,
    input  wire ctl_cmd_t  cmd,
    output dp_sts_t        sts
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Ring memories
    logic [7:0] rx_mem [FIFO_DEPTH];
    logic [7:0] tx_mem [FIFO_DEPTH];
    logic [7:0] rx_rdata_reg;
    logic [7:0] tx_rdata_reg;

    // FIFO state
    logic [PTR_W-1:0] rx_rp_reg, rx_rp_next, rx_wp_reg, rx_wp_next;
    logic [PTR_W-1:0] tx_rp_reg, tx_rp_next, tx_wp_reg, tx_wp_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next, tx_count_reg, tx_count_next;
    logic             tx_busy_reg, tx_busy_next;

    // Item and scan state
    logic [2:0]       op_reg;
    logic [7:0]       byte_reg;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [1:0]       nd_reg;
    logic [7:0]       d0_reg, d1_reg;
    logic             cr_reg, lf_reg;

    // Result register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, out_next;

    logic rx_full, tx_full, rx_we, tx_we;

    assign rx_full = (rx_count_reg == CNT_FULL);
    assign tx_full = (tx_count_reg == CNT_FULL);

    // Digit decode
    logic [7:0] d0_off, d1_off;
    logic       d0_ok, d1_ok;
    logic [6:0] num_value;

    assign d0_off    = d0_reg - CH_ZERO;
    assign d1_off    = d1_reg - CH_ZERO;
    assign d0_ok     = (d0_reg >= CH_ZERO) && (d0_reg <= CH_NINE);
    assign d1_ok     = (d1_reg >= CH_ZERO) && (d1_reg <= CH_NINE);
    assign num_value = (nd_reg == 2'd1) ? 7'(d0_off[3:0])
                     : 7'({d0_off[3:0], 3'b000}) + 7'({d0_off[3:0], 1'b0})
                       + 7'(d1_off[3:0]);

    // Scan pointer: the read address follows its next value, so the read
    // data register always holds the byte under the scan pointer.
    always_comb begin
        scan_ptr_next = scan_ptr_reg;
        left_next     = left_reg;
        if (cmd.load || cmd.rescan) begin
            scan_ptr_next = rx_rp_reg;
            left_next     = rx_count_reg;
        end else if (cmd.step) begin
            scan_ptr_next = ptr_inc(scan_ptr_reg);
            left_next     = left_reg - 1'b1;
        end
    end

    // Commit of one item
    always_comb begin
        rx_rp_next    = rx_rp_reg;
        rx_wp_next    = rx_wp_reg;
        rx_count_next = rx_count_reg;
        tx_rp_next    = tx_rp_reg;
        tx_wp_next    = tx_wp_reg;
        tx_count_next = tx_count_reg;
        tx_busy_next  = tx_busy_reg;
        out_next      = '0;
        rx_we         = 1'b0;
        tx_we         = 1'b0;
        if (cmd.finish) begin
            unique case (op_reg)
                OP_RX_BYTE: begin
                    if (rx_full) begin
                        out_next.status = STS_FULL;
                    end else begin
                        rx_we         = 1'b1;
                        rx_wp_next    = ptr_inc(rx_wp_reg);
                        rx_count_next = rx_count_reg + 1'b1;
                    end
                end
                OP_TX_DONE: begin
                    if (tx_count_reg != '0) begin
                        out_next.line_valid = 1'b1;
                        out_next.line_byte  = tx_rdata_reg;
                        tx_rp_next          = ptr_inc(tx_rp_reg);
                        tx_count_next       = tx_count_reg - 1'b1;
                    end else begin
                        tx_busy_next    = 1'b0;
                        out_next.status = STS_EMPTY;
                    end
                end
                OP_PUT: begin
                    if (tx_full) begin
                        out_next.status = STS_FULL;
                    end else if (!tx_busy_reg) begin
                        out_next.line_valid = 1'b1;
                        out_next.line_byte  = byte_reg;
                        tx_busy_next        = 1'b1;
                    end else begin
                        tx_we         = 1'b1;
                        tx_wp_next    = ptr_inc(tx_wp_reg);
                        tx_count_next = tx_count_reg + 1'b1;
                    end
                end
                OP_GET: begin
                    if (rx_count_reg != '0) begin
                        out_next.read_byte = rx_rdata_reg;
                        rx_rp_next         = ptr_inc(rx_rp_reg);
                        rx_count_next      = rx_count_reg - 1'b1;
                    end else begin
                        out_next.status = STS_EMPTY;
                    end
                end
                OP_GET_NUM: begin
                    if (rx_full) begin
                        rx_rp_next      = '0;
                        rx_wp_next      = '0;
                        rx_count_next   = '0;
                        tx_rp_next      = '0;
                        tx_wp_next      = '0;
                        tx_count_next   = '0;
                        tx_busy_next    = 1'b0;
                        out_next.status = STS_OVERFLOW;
                    end else if (!lf_reg) begin
                        out_next.status = STS_NO_LINE;
                    end else begin
                        rx_rp_next    = scan_ptr_reg;
                        rx_count_next = left_reg;
                        if (!cr_reg || nd_reg == 2'd0 || !d0_ok
                                || (nd_reg == 2'd2 && !d1_ok)) begin
                            out_next.status = STS_INVALID;
                        end else begin
                            out_next.number_value = num_value;
                        end
                    end
                end
                default: begin
                    out_next = '0;
                end
            endcase
        end
    end

    // Result handshake
    assign m_valid_next = cmd.finish ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_rp_reg    <= '0;
            rx_wp_reg    <= '0;
            rx_count_reg <= '0;
            tx_rp_reg    <= '0;
            tx_wp_reg    <= '0;
            tx_count_reg <= '0;
            tx_busy_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            op_reg       <= '0;
            scan_ptr_reg <= '0;
            left_reg     <= '0;
            nd_reg       <= '0;
            cr_reg       <= 1'b0;
            lf_reg       <= 1'b0;
        end else begin
            rx_rp_reg    <= rx_rp_next;
            rx_wp_reg    <= rx_wp_next;
            rx_count_reg <= rx_count_next;
            tx_rp_reg    <= tx_rp_next;
            tx_wp_reg    <= tx_wp_next;
            tx_count_reg <= tx_count_next;
            tx_busy_reg  <= tx_busy_next;
            m_valid_reg  <= m_valid_next;
            scan_ptr_reg <= scan_ptr_next;
            left_reg     <= left_next;
            if (cmd.load) begin
                op_reg <= s_data.operation;
                nd_reg <= '0;
                cr_reg <= 1'b0;
                lf_reg <= 1'b0;
            end else begin
                if (cmd.take && nd_reg != 2'd2) begin
                    nd_reg <= nd_reg + 1'b1;
                end
                if (cmd.mark_cr) begin
                    cr_reg <= 1'b1;
                end
                if (cmd.rescan) begin
                    lf_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= s_data.data_byte;
        end
        if (cmd.take && nd_reg == 2'd0) begin
            d0_reg <= rx_rdata_reg;
        end
        if (cmd.take && nd_reg == 2'd1) begin
            d1_reg <= rx_rdata_reg;
        end
        if (cmd.finish) begin
            m_data_reg <= out_next;
        end
    end

    // Receive memory
    always_ff @(posedge aclk) begin
        if (rx_we) begin
            rx_mem[rx_wp_reg] <= byte_reg;
        end
        rx_rdata_reg <= rx_mem[scan_ptr_next];
    end

    // Transmit memory
    always_ff @(posedge aclk) begin
        if (tx_we) begin
            tx_mem[tx_wp_reg] <= byte_reg;
        end
        tx_rdata_reg <= tx_mem[tx_rp_next];
    end

    // Status to controller
    always_comb begin
        sts.op         = op_reg;
        sts.rx_full    = rx_full;
        sts.left_zero  = (left_reg == '0);
        sts.left_one   = (left_reg == CNT_W'(1));
        sts.byte_is_lf = (rx_rdata_reg == CH_LF);
        sts.byte_is_cr = (rx_rdata_reg == CH_CR);
        sts.out_free   = !m_valid_reg || m_ready;
    end

    `BULE_ASSERT_NOW(a_rx_count_bound, aclk, aresetn, 1'b1, rx_count_reg <= CNT_FULL, "rx count above depth")
    `BULE_ASSERT_NOW(a_tx_queue_busy, aclk, aresetn, tx_count_reg != '0, tx_busy_reg, "tx bytes queued while idle")
    `BULE_ASSERT_NOW(a_step_has_byte, aclk, aresetn, cmd.step, left_reg != '0, "scan step past the last byte")
    `BULE_ASSERT_NOW(a_finish_slot, aclk, aresetn, cmd.finish, !m_valid_reg || m_ready, "result overwritten")
    `BULE_ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_valid_reg, "result not presented")

endmodule

`default_nettype wire
